// File: hdl/jtsl_pkg.sv
// Shared types, constants and field widths of the joint torque safety limiter.
package jtsl_pkg;

    localparam int JOINT_COUNT_DEF = 7;

    localparam int JOINT_W    = 4;
    localparam int OP_W       = 2;
    localparam int TORQUE_W   = 20;
    localparam int MAX_W      = 19;
    localparam int RATE_W     = 20;
    localparam int LJC_W      = 5;
    localparam int IVL_W      = 16;
    localparam int TEMP_W     = 13;
    localparam int DERATE_W   = 17;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // queue depths: request queue between front and back, result queue at the output
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

    // derating: full below 60 C, zero from 85 C, in 1/16 C
    localparam logic [DERATE_W-1:0]      DERATE_FULL = 17'd65536;
    localparam logic signed [TEMP_W-1:0] TEMP_KNEE   = 13'sd960;
    localparam logic signed [TEMP_W-1:0] TEMP_CUT    = 13'sd1360;
    localparam int                       SPAN_W      = 9;
    // floor(x * 4096 / 25) = (x * ceil(2^30 / 25)) >> 18
    localparam int                       RECIP_W     = 26;
    localparam logic [RECIP_W-1:0]       DIV25_RECIP = 26'd42949673;
    localparam int                       DIV25_SHIFT = 18;

    localparam int DERATE_SHIFT = 16;
    localparam int SLEW_SHIFT   = 20;

    // reset values of the configuration registers
    localparam logic [MAX_W-1:0]  MAX_LARGE_RST   = 19'd17818;
    localparam logic [MAX_W-1:0]  MAX_SMALL_RST   = 19'd2458;
    localparam logic [RATE_W-1:0] SLEW_LARGE_RST  = 20'd222720;
    localparam logic [RATE_W-1:0] SLEW_SMALL_RST  = 20'd30720;
    localparam logic [LJC_W-1:0]  LARGE_COUNT_RST = 5'd4;
    localparam logic [MAX_W-1:0]  COLL_THRESH_RST = 19'd1280;

    typedef enum logic [OP_W-1:0] {
        OP_COMMAND = 2'd0,
        OP_TEMP    = 2'd1,
        OP_CALIB   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_LARGE   = 3'd0,
        REG_MAX_SMALL   = 3'd1,
        REG_SLEW_LARGE  = 3'd2,
        REG_SLEW_SMALL  = 3'd3,
        REG_LARGE_COUNT = 3'd4,
        REG_COLL_THRESH = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [MAX_W-1:0]  max_torque_large;
        logic [MAX_W-1:0]  max_torque_small;
        logic [RATE_W-1:0] slew_rate_large;
        logic [RATE_W-1:0] slew_rate_small;
        logic [LJC_W-1:0]  large_joint_count;
        logic [MAX_W-1:0]  collision_threshold;
    } cfg_t;

    // classified request as held in the queue between front and back
    typedef struct packed {
        op_t                        op;
        logic                       joint_ok;
        logic                       big_joint;
        logic [JOINT_W-1:0]         joint;
        logic signed [TORQUE_W-1:0] torque_req;
        logic signed [TORQUE_W-1:0] torque_sense;
        logic [IVL_W-1:0]           max_step;
        logic [DERATE_W-1:0]        derate;
    } item_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] safe_torque;
        logic                       collision;
        logic                       rate_limited;
        logic                       thermal_stop;
        logic [CNT_W-1:0]           stop_count;
        logic [CNT_W-1:0]           command_count;
    } result_t;

endpackage

// File: hdl/jtsl_fifo.sv
// Small flip-flop queue with combinational head read.
module jtsl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == LVL_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/jtsl_front.sv
// Front end: classifies a request, works out derating and slew step ahead of the back end.
module jtsl_front #(
    parameter int JOINT_COUNT = jtsl_pkg::JOINT_COUNT_DEF
) (
    input  jtsl_pkg::cfg_t                               cfg,
    input  logic [jtsl_pkg::OP_W-1:0]                    op,
    input  logic [jtsl_pkg::JOINT_W-1:0]                 joint,
    input  logic signed [jtsl_pkg::TORQUE_W-1:0]         torque_req,
    input  logic signed [jtsl_pkg::TORQUE_W-1:0]         torque_sense,
    input  logic [jtsl_pkg::IVL_W-1:0]                   interval,
    input  logic signed [jtsl_pkg::TEMP_W-1:0]           temperature,
    output jtsl_pkg::item_t                              item
);

    localparam logic [jtsl_pkg::JOINT_W:0] JOINT_LIMIT = JOINT_COUNT[jtsl_pkg::JOINT_W:0];
    localparam int SCALED_W = jtsl_pkg::SPAN_W + jtsl_pkg::RECIP_W;
    localparam int STEP_W   = jtsl_pkg::RATE_W + jtsl_pkg::IVL_W;

    logic signed [jtsl_pkg::TEMP_W:0]   span_full;
    logic [jtsl_pkg::SPAN_W-1:0]        span;
    logic [SCALED_W-1:0]                scaled;
    logic [jtsl_pkg::DERATE_W-1:0]      derate;
    logic                               big_joint;
    logic [jtsl_pkg::RATE_W-1:0]        rate;
    logic [STEP_W-1:0]                  step_prod;

    // derating slope: (85 C - t) * 4096 / 25, only used on the linear stretch
    always_comb
    begin
        span_full = $signed({jtsl_pkg::TEMP_CUT[jtsl_pkg::TEMP_W-1], jtsl_pkg::TEMP_CUT})
                  - $signed({temperature[jtsl_pkg::TEMP_W-1], temperature});
        span      = span_full[jtsl_pkg::SPAN_W-1:0];
        scaled    = SCALED_W'(span) * SCALED_W'(jtsl_pkg::DIV25_RECIP);
        if (temperature < jtsl_pkg::TEMP_KNEE)
        begin
            derate = jtsl_pkg::DERATE_FULL;
        end
        else if (temperature < jtsl_pkg::TEMP_CUT)
        begin
            derate = scaled[jtsl_pkg::DIV25_SHIFT +: jtsl_pkg::DERATE_W];
        end
        else
        begin
            derate = '0;
        end
    end

    // allowed change this interval, depends on configuration, joint class and interval
    always_comb
    begin
        big_joint = ({1'b0, joint} < cfg.large_joint_count);
        rate      = big_joint ? cfg.slew_rate_large : cfg.slew_rate_small;
        step_prod = STEP_W'(rate) * STEP_W'(interval);
    end

    always_comb
    begin
        item.op           = jtsl_pkg::op_t'(op);
        item.joint_ok     = ({1'b0, joint} < JOINT_LIMIT);
        item.big_joint    = big_joint;
        item.joint        = joint;
        item.torque_req   = torque_req;
        item.torque_sense = torque_sense;
        item.max_step     = step_prod[jtsl_pkg::SLEW_SHIFT +: jtsl_pkg::IVL_W];
        item.derate       = derate;
    end

endmodule

// File: hdl/jtsl_back.sv
// Back end: per-joint state, collision check, derated clamp and slew limit, counters.
module jtsl_back #(
    parameter int JOINT_COUNT = jtsl_pkg::JOINT_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  jtsl_pkg::cfg_t                    cfg,
    input  jtsl_pkg::item_t                   item,
    input  logic                              item_avail,
    input  logic [jtsl_pkg::OUT_LVL_W-1:0]    out_level,
    output logic                              item_take,
    output jtsl_pkg::result_t                 result,
    output logic                              result_valid
);

    localparam int JIDX_W  = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int TW      = jtsl_pkg::TORQUE_W;
    localparam int MW      = jtsl_pkg::MAX_W;
    localparam int DW      = jtsl_pkg::DERATE_W;
    localparam int EFF_P_W = MW + DW;
    localparam int LVL_W   = jtsl_pkg::OUT_LVL_W;

    // stage 1 state: derating and collision history
    logic [DW-1:0]        derate_reg   [JOINT_COUNT];
    logic signed [TW-1:0] baseline_reg [JOINT_COUNT];
    logic signed [TW-1:0] prev_one_reg [JOINT_COUNT];
    logic signed [TW-1:0] prev_two_reg [JOINT_COUNT];
    logic [1:0]           fill_reg     [JOINT_COUNT];
    logic                 calib_reg    [JOINT_COUNT];

    // stage 2 state: last output and counters
    logic signed [TW-1:0]           last_out_reg [JOINT_COUNT];
    logic [jtsl_pkg::CNT_W-1:0]     stops_reg, stops_next;
    logic [jtsl_pkg::CNT_W-1:0]     cmds_reg, cmds_next;

    // stage 2 pipeline register
    logic                   s2_valid_reg;
    jtsl_pkg::op_t          s2_op_reg;
    logic                   s2_ok_reg;
    logic [JIDX_W-1:0]      s2_jidx_reg;
    logic                   s2_coll_reg;
    logic [MW-1:0]          s2_eff_reg;
    logic signed [TW-1:0]   s2_desired_reg;
    logic [jtsl_pkg::IVL_W-1:0] s2_step_reg;

    logic [LVL_W:0]         in_flight;
    logic [JIDX_W-1:0]      jidx;
    logic signed [TW+2:0]   jerk;
    logic [TW+2:0]          jerk_mag;
    logic signed [TW:0]     dev;
    logic [TW:0]            dev_mag;
    logic                   hit;
    logic [MW-1:0]          mx;
    logic [EFF_P_W-1:0]     eff_prod;

    logic                   is_cmd;
    logic                   thermal;
    logic                   drive;
    logic                   limited;
    logic signed [TW:0]     eff_s;
    logic signed [TW:0]     clamped;
    logic signed [TW+1:0]   last_s;
    logic signed [TW+1:0]   delta;
    logic signed [TW+1:0]   step_s;
    logic signed [TW+1:0]   c_out;

    // results still owed to the output queue must always fit in it
    always_comb
    begin
        in_flight = {1'b0, out_level} + (LVL_W+1)'(s2_valid_reg);
        item_take = item_avail && (in_flight < (LVL_W+1)'(jtsl_pkg::OUT_DEPTH));
    end

    // stage 1: collision test and derated maximum
    always_comb
    begin
        jidx     = item.joint[JIDX_W-1:0];
        jerk     = (TW+3)'(item.torque_sense) - ((TW+3)'(prev_one_reg[jidx]) <<< 1)
                 + (TW+3)'(prev_two_reg[jidx]);
        jerk_mag = jerk[TW+2] ? (TW+3)'(-jerk) : (TW+3)'(jerk);
        dev      = (TW+1)'(item.torque_sense) - (TW+1)'(baseline_reg[jidx]);
        dev_mag  = dev[TW] ? (TW+1)'(-dev) : (TW+1)'(dev);
        hit      = 1'b0;
        if (calib_reg[jidx])
        begin
            if ((fill_reg[jidx] >= 2'd2) && ({jerk_mag, 1'b0} > (TW+4)'(cfg.collision_threshold)))
            begin
                hit = 1'b1;
            end
            if (dev_mag > (TW+1)'(cfg.collision_threshold))
            begin
                hit = 1'b1;
            end
        end
        mx       = item.big_joint ? cfg.max_torque_large : cfg.max_torque_small;
        eff_prod = EFF_P_W'(mx) * EFF_P_W'(derate_reg[jidx]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < JOINT_COUNT; j++)
            begin
                derate_reg[j]   <= jtsl_pkg::DERATE_FULL;
                baseline_reg[j] <= '0;
                prev_one_reg[j] <= '0;
                prev_two_reg[j] <= '0;
                fill_reg[j]     <= '0;
                calib_reg[j]    <= 1'b0;
            end
        end
        else if (item_take && item.joint_ok)
        begin
            unique case (item.op)
                jtsl_pkg::OP_TEMP:
                begin
                    derate_reg[jidx] <= item.derate;
                end
                jtsl_pkg::OP_CALIB:
                begin
                    baseline_reg[jidx] <= item.torque_sense;
                    prev_one_reg[jidx] <= '0;
                    prev_two_reg[jidx] <= '0;
                    fill_reg[jidx]     <= '0;
                    calib_reg[jidx]    <= 1'b1;
                end
                jtsl_pkg::OP_COMMAND:
                begin
                    if (calib_reg[jidx])
                    begin
                        prev_two_reg[jidx] <= prev_one_reg[jidx];
                        prev_one_reg[jidx] <= item.torque_sense;
                        if (fill_reg[jidx] != 2'd3)
                        begin
                            fill_reg[jidx] <= fill_reg[jidx] + 2'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= item_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s2_op_reg      <= item.op;
            s2_ok_reg      <= item.joint_ok;
            s2_jidx_reg    <= jidx;
            s2_coll_reg    <= hit;
            s2_eff_reg     <= eff_prod[jtsl_pkg::DERATE_SHIFT +: MW];
            s2_desired_reg <= item.torque_req;
            s2_step_reg    <= item.max_step;
        end
    end

    // stage 2: clamp to the derated maximum, then slew limit against the last output
    always_comb
    begin
        is_cmd  = (s2_op_reg == jtsl_pkg::OP_COMMAND);
        thermal = !s2_coll_reg && (s2_eff_reg == '0);
        drive   = is_cmd && s2_ok_reg && !s2_coll_reg && !thermal;

        eff_s   = $signed({2'b00, s2_eff_reg});
        clamped = (TW+1)'(s2_desired_reg);
        if (clamped > eff_s)
        begin
            clamped = eff_s;
        end
        else if (clamped < -eff_s)
        begin
            clamped = -eff_s;
        end

        last_s  = (TW+2)'(last_out_reg[s2_jidx_reg]);
        delta   = (TW+2)'(clamped) - last_s;
        step_s  = $signed({6'b000000, s2_step_reg});
        limited = 1'b0;
        c_out   = (TW+2)'(clamped);
        if (delta > step_s)
        begin
            c_out   = last_s + step_s;
            limited = 1'b1;
        end
        else if (delta < -step_s)
        begin
            c_out   = last_s - step_s;
            limited = 1'b1;
        end

        cmds_next  = (is_cmd && (cmds_reg != '1)) ? cmds_reg + 1'b1 : cmds_reg;
        stops_next = stops_reg;
        if (is_cmd && s2_ok_reg && (s2_coll_reg || thermal) && (stops_reg != '1))
        begin
            stops_next = stops_reg + 1'b1;
        end

        result_valid         = s2_valid_reg;
        result.safe_torque   = drive ? c_out[TW-1:0] : '0;
        result.collision     = is_cmd && s2_ok_reg && s2_coll_reg;
        result.rate_limited  = drive && limited;
        result.thermal_stop  = is_cmd && s2_ok_reg && thermal;
        result.stop_count    = stops_next;
        result.command_count = cmds_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < JOINT_COUNT; j++)
            begin
                last_out_reg[j] <= '0;
            end
            stops_reg <= '0;
            cmds_reg  <= '0;
        end
        else if (s2_valid_reg)
        begin
            stops_reg <= stops_next;
            cmds_reg  <= cmds_next;
            if (drive)
            begin
                last_out_reg[s2_jidx_reg] <= c_out[TW-1:0];
            end
        end
    end

endmodule

// File: hdl/joint_torque_safety_limiter_top.sv
// Top level of the joint torque safety limiter: config registers, queues, front and back end.
//
// Usage
//   Requests enter through a queue-style port: a request is taken at a rising edge with
//   push high and full low. op selects torque command, temperature update or calibrate.
//   Every request gives exactly one result, read from a queue-style port: the oldest
//   result sits on the result ports while empty is low and leaves on an edge with pop high.
//   Configuration is written through cfg_write / cfg_index / cfg_data, one register per edge;
//   the user must write only while no request is in flight, as the block does not enforce it.
// Throughput and pipeline
//   One request per cycle sustained while results are popped. A result is visible once it
//   has passed the request queue, the stage-2 pipeline register and the result queue. The
//   rate is set by the per-joint last-output update of the second back-end stage, which
//   is registered before the next command, so same-joint commands may follow directly.
// Reset
//   rst_n clears both queues, loads the default limits, sets every joint to full derating,
//   uncalibrated, zero history and zero last output, and clears both counters. No sweep.
// Back-pressure
//   The result queue holds four results. The back end only draws a request when the
//   result queue has room for it plus the one still in its pipeline; once that runs out
//   the two-deep request queue fills and full rises.
module joint_torque_safety_limiter_top #(
    parameter int JOINT_COUNT = jtsl_pkg::JOINT_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  push,
    output logic                                  full,
    input  logic [jtsl_pkg::OP_W-1:0]             op,
    input  logic [jtsl_pkg::JOINT_W-1:0]          joint,
    input  logic signed [jtsl_pkg::TORQUE_W-1:0]  torque_req,
    input  logic signed [jtsl_pkg::TORQUE_W-1:0]  torque_sense,
    input  logic [jtsl_pkg::IVL_W-1:0]            interval,
    input  logic signed [jtsl_pkg::TEMP_W-1:0]    temperature,
    // result channel
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [jtsl_pkg::TORQUE_W-1:0]  safe_torque,
    output logic                                  collision,
    output logic                                  rate_limited,
    output logic                                  thermal_stop,
    output logic [jtsl_pkg::CNT_W-1:0]            stop_count,
    output logic [jtsl_pkg::CNT_W-1:0]            command_count,
    // configuration write port
    input  logic                                  cfg_write,
    input  logic [jtsl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jtsl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    jtsl_pkg::cfg_t    cfg_reg;
    jtsl_pkg::item_t   front_item;
    jtsl_pkg::item_t   mid_item;
    logic              mid_empty;
    logic              mid_pop;
    jtsl_pkg::result_t res;
    logic              res_valid;
    jtsl_pkg::result_t out_res;
    logic              out_full;
    logic [jtsl_pkg::OUT_LVL_W-1:0] out_level;

    // configuration registers; writes to unlisted indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_torque_large    <= jtsl_pkg::MAX_LARGE_RST;
            cfg_reg.max_torque_small    <= jtsl_pkg::MAX_SMALL_RST;
            cfg_reg.slew_rate_large     <= jtsl_pkg::SLEW_LARGE_RST;
            cfg_reg.slew_rate_small     <= jtsl_pkg::SLEW_SMALL_RST;
            cfg_reg.large_joint_count   <= jtsl_pkg::LARGE_COUNT_RST;
            cfg_reg.collision_threshold <= jtsl_pkg::COLL_THRESH_RST;
        end
        else if (cfg_write)
        begin
            unique case (jtsl_pkg::cfg_idx_t'(cfg_index))
                jtsl_pkg::REG_MAX_LARGE:
                    cfg_reg.max_torque_large <= cfg_data[jtsl_pkg::MAX_W-1:0];
                jtsl_pkg::REG_MAX_SMALL:
                    cfg_reg.max_torque_small <= cfg_data[jtsl_pkg::MAX_W-1:0];
                jtsl_pkg::REG_SLEW_LARGE:
                    cfg_reg.slew_rate_large <= cfg_data[jtsl_pkg::RATE_W-1:0];
                jtsl_pkg::REG_SLEW_SMALL:
                    cfg_reg.slew_rate_small <= cfg_data[jtsl_pkg::RATE_W-1:0];
                jtsl_pkg::REG_LARGE_COUNT:
                    cfg_reg.large_joint_count <= cfg_data[jtsl_pkg::LJC_W-1:0];
                jtsl_pkg::REG_COLL_THRESH:
                    cfg_reg.collision_threshold <= cfg_data[jtsl_pkg::MAX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front end classifies straight off the request ports
    jtsl_front #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_front (
        .cfg          (cfg_reg),
        .op           (op),
        .joint        (joint),
        .torque_req   (torque_req),
        .torque_sense (torque_sense),
        .interval     (interval),
        .temperature  (temperature),
        .item         (front_item)
    );

    // request queue decoupling front and back
    jtsl_fifo #(
        .WIDTH ($bits(jtsl_pkg::item_t)),
        .DEPTH (jtsl_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty),
        .count ()
    );

    jtsl_back #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (mid_item),
        .item_avail   (!mid_empty),
        .out_level    (out_level),
        .item_take    (mid_pop),
        .result       (res),
        .result_valid (res_valid)
    );

    // result queue; also parts the back end from a stalled receiver
    jtsl_fifo #(
        .WIDTH ($bits(jtsl_pkg::result_t)),
        .DEPTH (jtsl_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty),
        .count (out_level)
    );

    assign safe_torque   = out_res.safe_torque;
    assign collision     = out_res.collision;
    assign rate_limited  = out_res.rate_limited;
    assign thermal_stop  = out_res.thermal_stop;
    assign stop_count    = out_res.stop_count;
    assign command_count = out_res.command_count;

`ifndef SYNTHESIS
    // the back end's credit check must keep the result queue from overflowing
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_full)
        else $error("result written into a full result queue");

    // a stop is either a collision or a thermal stop, never both
    a_single_stop: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(collision && thermal_stop))
        else $error("collision and thermal stop on one result");

    // any stop forces a zero torque and no slew flag
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (collision || thermal_stop)) |-> (safe_torque == '0 && !rate_limited))
        else $error("stopped result carries torque");
`endif

endmodule
